@@ hdl/fpwc_pkg.sv @@
// ----------------------------------------------------------------------------
// fpwc_pkg
// Types and constants shared by the flash phrase write combiner modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fpwc_pkg;

  // Phrase geometry
  localparam int PHRASE_BYTES = 8;
  localparam int OFF_W        = $clog2(PHRASE_BYTES);
  localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(PHRASE_BYTES - 1);

  // Request operations
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_ERASE = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  // Result commands
  localparam logic [1:0] CMD_STATUS  = 2'd0;
  localparam logic [1:0] CMD_PROGRAM = 2'd1;
  localparam logic [1:0] CMD_ERASE   = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_APP_BASE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BACKUP_BASE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_SIZE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR_LOG2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLASH_ON     = 3'd4;

  localparam logic [4:0] SECTOR_LOG2_RST = 5'd10;

  // Request queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Result FIFO in the back end; one request pushes up to three results
  localparam int OUT_DEPTH = 4;
  localparam int OPTR_W    = $clog2(OUT_DEPTH);
  localparam int MAX_RES   = 3;

  typedef struct packed {
    logic [31:0] app_base;
    logic [31:0] backup_base;
    logic [31:0] slot_size;
    logic [4:0]  sector_log2;
    logic        flash_on;
  } cfg_t;

  // Classified request, as handed from front to back
  typedef struct packed {
    logic [1:0]       op;
    logic [7:0]       data;
    logic             wr_ok;
    logic [31:0]      pa;
    logic [OFF_W-1:0] off;
    logic             er_ok;
    logic [31:0]      es;
    logic [31:0]      elen;
  } cls_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] flash_address;
    logic [63:0] phrase_data;
    logic [31:0] erase_length;
    logic        status;
    logic        last;
  } rec_t;

endpackage

`default_nettype wire

@@ hdl/flash_phrase_write_combiner.sv @@
// ----------------------------------------------------------------------------
// flash_phrase_write_combiner
// Gathers byte writes into flash phrases, issues phrase programs and
// sector-aligned erases inside the backup slot.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in_      request    in_valid/in_ready    operation, address, data_byte,
//                                           byte_count
//  out_     result     out_valid/out_ready  command, flash_address,
//                                           phrase_data, erase_length,
//                                           status, last
//  cfg_     write      cfg_wr_en            cfg_index, cfg_data
//
// Each request yields zero to two commands and one status result (last=1).
// The first result passes the four classifier stages, the request queue and
// the result FIFO before it is presented. One request is taken per cycle
// while the front end is not stalled; the output port emits one result per
// cycle while out_ready is high. The back end takes a request only while the
// result FIFO has room for three more results. Reset (synchronous) empties
// all queues and restores the buffer to clean, all 0xFF. Either side may stall freely.
// ----------------------------------------------------------------------------
`default_nettype none

module flash_phrase_write_combiner
  import fpwc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           in_operation,
  input  wire logic [31:0]          in_address,
  input  wire logic [7:0]           in_data_byte,
  input  wire logic [31:0]          in_byte_count,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [1:0]                out_command,
  output logic [31:0]               out_flash_address,
  output logic [63:0]               out_phrase_data,
  output logic [31:0]               out_erase_length,
  output logic                      out_status,
  output logic                      out_last
);

  cfg_t cfg_r;
  logic cls_valid, cls_ready;
  cls_t cls;
  logic req_valid, req_ready;
  cls_t req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.app_base    <= '0;
      cfg_r.backup_base <= '0;
      cfg_r.slot_size   <= '0;
      cfg_r.sector_log2 <= SECTOR_LOG2_RST;
      cfg_r.flash_on    <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_APP_BASE:    cfg_r.app_base    <= cfg_data;
        REG_BACKUP_BASE: cfg_r.backup_base <= cfg_data;
        REG_SLOT_SIZE:   cfg_r.slot_size   <= cfg_data;
        REG_SECTOR_LOG2: cfg_r.sector_log2 <= cfg_data[4:0];
        REG_FLASH_ON:    cfg_r.flash_on    <= cfg_data[0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  fpwc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_address    (in_address),
    .in_data_byte  (in_data_byte),
    .in_byte_count (in_byte_count),
    .cls_valid     (cls_valid),
    .cls_ready     (cls_ready),
    .cls           (cls)
  );

  fpwc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cls_valid),
    .wr_ready (cls_ready),
    .wr_data  (cls),
    .rd_valid (req_valid),
    .rd_ready (req_ready),
    .rd_data  (req)
  );

  fpwc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .req_valid         (req_valid),
    .req_ready         (req_ready),
    .req               (req),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_command       (out_command),
    .out_flash_address (out_flash_address),
    .out_phrase_data   (out_phrase_data),
    .out_erase_length  (out_erase_length),
    .out_status        (out_status),
    .out_last          (out_last)
  );

endmodule

`default_nettype wire

@@ hdl/fpwc_front.sv @@
// ----------------------------------------------------------------------------
// fpwc_front
// Four-stage classifier: maps logical addresses into the backup slot,
// range-checks writes and erases and aligns erase ranges to sectors.
// ----------------------------------------------------------------------------
`default_nettype none

module fpwc_front
  import fpwc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic [31:0] in_address,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic [31:0] in_byte_count,
  output logic             cls_valid,
  input  wire logic        cls_ready,
  output cls_t             cls
);

  logic rdy1, rdy2, rdy3, rdy4;

  // stage 1: offset from application base
  logic        v1_r;
  logic [1:0]  op1_r;
  logic [7:0]  data1_r;
  logic [31:0] cnt1_r;
  logic [31:0] d1_r;
  logic        ge1_r;

  // stage 2: mapped address and first range check
  logic        v2_r;
  logic [1:0]  op2_r;
  logic [7:0]  data2_r;
  logic [31:0] mapped2_r;
  logic [31:0] mend2_r;
  logic        in1_2_r;
  logic        wrok2_r;

  // stage 3: sector alignment
  logic        v3_r;
  logic [1:0]  op3_r;
  logic [7:0]  data3_r;
  logic [31:0] mapped3_r;
  logic        in1_3_r;
  logic        wrok3_r;
  logic [31:0] es3_r;
  logic [31:0] elen3_r;

  // stage 4: output register
  logic        v4_r;
  cls_t        cls_r;

  logic [31:0] room2;
  logic [31:0] mapped2;
  logic [31:0] sec_m1;
  logic [31:0] ee3;
  logic [31:0] es3;
  logic [31:0] room4;
  logic        in2_4;

  assign rdy4     = !v4_r || cls_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign cls_valid = v4_r;
  assign cls       = cls_r;

  always_comb begin
    room2   = cfg.slot_size - d1_r;
    mapped2 = cfg.backup_base + d1_r;
    sec_m1  = (32'd1 << cfg.sector_log2) - 32'd1;
    es3     = mapped2_r & ~sec_m1;
    ee3     = (mend2_r + sec_m1) & ~sec_m1;
    room4   = cfg.slot_size - (es3_r - cfg.backup_base);
    in2_4   = (elen3_r != 32'd0) && (es3_r >= cfg.backup_base) && (elen3_r <= room4);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      op1_r   <= in_operation;
      data1_r <= in_data_byte;
      cnt1_r  <= in_byte_count;
      d1_r    <= in_address - cfg.app_base;
      ge1_r   <= in_address >= cfg.app_base;
    end
    if (rdy2) begin
      op2_r     <= op1_r;
      data2_r   <= data1_r;
      mapped2_r <= mapped2;
      mend2_r   <= mapped2 + cnt1_r;
      in1_2_r   <= ge1_r && (cnt1_r != 32'd0) && (cnt1_r <= room2);
      wrok2_r   <= ge1_r && (room2 != 32'd0);
    end
    if (rdy3) begin
      op3_r     <= op2_r;
      data3_r   <= data2_r;
      mapped3_r <= mapped2_r;
      in1_3_r   <= in1_2_r;
      wrok3_r   <= wrok2_r;
      es3_r     <= es3;
      elen3_r   <= ee3 - es3;
    end
    if (rdy4) begin
      cls_r.op    <= op3_r;
      cls_r.data  <= data3_r;
      cls_r.wr_ok <= wrok3_r;
      cls_r.pa    <= {mapped3_r[31:OFF_W], OFF_W'(0)};
      cls_r.off   <= mapped3_r[OFF_W-1:0];
      cls_r.er_ok <= in1_3_r && in2_4;
      cls_r.es    <= es3_r;
      cls_r.elen  <= elen3_r;
    end
  end

endmodule

`default_nettype wire

@@ hdl/fpwc_queue.sv @@
// ----------------------------------------------------------------------------
// fpwc_queue
// Small FIFO of classified requests between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module fpwc_queue
  import fpwc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_valid,
  output logic      wr_ready,
  input  wire cls_t wr_data,
  output logic      rd_valid,
  input  wire logic rd_ready,
  output cls_t      rd_data
);

  cls_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] head_r, tail_r;
  logic [QPTR_W:0]   cnt_r;
  logic              push, pop;

  assign wr_ready = cnt_r != (QPTR_W+1)'(QDEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[head_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        tail_r <= tail_r + QPTR_W'(1);
      end
      if (pop) begin
        head_r <= head_r + QPTR_W'(1);
      end
      cnt_r <= cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[tail_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

@@ hdl/fpwc_back.sv @@
// ----------------------------------------------------------------------------
// fpwc_back
// Phrase buffer and sticky error state: carries out at most one classified
// request per cycle and pushes its program/erase/status results into a
// result FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

module fpwc_back
  import fpwc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire cls_t        req,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_command,
  output logic [31:0]      out_flash_address,
  output logic [63:0]      out_phrase_data,
  output logic [31:0]      out_erase_length,
  output logic             out_status,
  output logic             out_last
);

  // buffer state
  logic                        dirty_r;
  logic [31:0]                 bpa_r;
  logic [PHRASE_BYTES-1:0][7:0] bytes_r;
  logic                        sticky_r;

  logic                        dirty;
  logic [31:0]                 bpa;
  logic [PHRASE_BYTES-1:0][7:0] bytes;
  logic                        sticky;
  logic                        err;
  logic [1:0]                  n;
  rec_t                        recs [MAX_RES];

  // result FIFO
  rec_t              fifo_r [OUT_DEPTH];
  logic [OPTR_W-1:0] head_r, tail_r;
  logic [OPTR_W:0]   cnt_r;
  logic              take, pop;
  logic [1:0]        npush;

  assign take      = req_valid && (cnt_r <= (OPTR_W+1)'(OUT_DEPTH - MAX_RES));
  assign req_ready = take;
  assign out_valid = cnt_r != '0;
  assign pop       = out_valid && out_ready;
  assign npush     = n + 2'd1;

  assign out_command       = fifo_r[head_r].command;
  assign out_flash_address = fifo_r[head_r].flash_address;
  assign out_phrase_data   = fifo_r[head_r].phrase_data;
  assign out_erase_length  = fifo_r[head_r].erase_length;
  assign out_status        = fifo_r[head_r].status;
  assign out_last          = fifo_r[head_r].last;

  always_comb begin
    dirty  = dirty_r;
    bpa    = bpa_r;
    bytes  = bytes_r;
    sticky = sticky_r;
    err    = 1'b0;
    n      = 2'd0;
    for (int k = 0; k < MAX_RES; k++) begin
      recs[k] = '0;
    end

    unique case (req.op)
      OP_WRITE: begin
        if (sticky) begin
          err = 1'b1;
        end else if (!req.wr_ok) begin
          sticky = 1'b1;
          err    = 1'b1;
        end else begin
          // a different phrase: flush the old one, then start fresh
          if (!dirty || bpa != req.pa) begin
            if (dirty) begin
              dirty = 1'b0;
              if (cfg.flash_on) begin
                recs[n].command       = CMD_PROGRAM;
                recs[n].flash_address = bpa;
                recs[n].phrase_data   = 64'(bytes);
                n = n + 2'd1;
              end else begin
                err    = 1'b1;
                sticky = 1'b1;
              end
            end
            if (!err) begin
              bpa   = req.pa;
              bytes = '1;
              dirty = 1'b0;
            end
          end
          if (!err) begin
            bytes[req.off] = req.data;
            dirty = 1'b1;
            // last byte of the phrase: program right away
            if (req.off == OFF_LAST) begin
              dirty = 1'b0;
              if (cfg.flash_on) begin
                recs[n].command       = CMD_PROGRAM;
                recs[n].flash_address = bpa;
                recs[n].phrase_data   = 64'(bytes);
                n = n + 2'd1;
              end else begin
                err    = 1'b1;
                sticky = 1'b1;
              end
            end
          end
        end
      end
      OP_ERASE: begin
        if (dirty) begin
          dirty = 1'b0;
          if (cfg.flash_on) begin
            recs[n].command       = CMD_PROGRAM;
            recs[n].flash_address = bpa;
            recs[n].phrase_data   = 64'(bytes);
            n = n + 2'd1;
          end else begin
            err    = 1'b1;
            sticky = 1'b1;
          end
        end
        if (!err) begin
          if (!req.er_ok) begin
            err = 1'b1;
          end else begin
            if (cfg.flash_on) begin
              recs[n].command       = CMD_ERASE;
              recs[n].flash_address = req.es;
              recs[n].erase_length  = req.elen;
              n = n + 2'd1;
              sticky = 1'b0;
            end else begin
              sticky = 1'b1;
              err    = 1'b1;
            end
            bpa   = '0;
            bytes = '1;
            dirty = 1'b0;
          end
        end
      end
      OP_FLUSH: begin
        if (dirty) begin
          dirty = 1'b0;
          if (cfg.flash_on) begin
            recs[n].command       = CMD_PROGRAM;
            recs[n].flash_address = bpa;
            recs[n].phrase_data   = 64'(bytes);
            n = n + 2'd1;
          end else begin
            err    = 1'b1;
            sticky = 1'b1;
          end
        end
      end
      default: begin
        err = 1'b1;
      end
    endcase

    recs[n].command = CMD_STATUS;
    recs[n].status  = err;
    recs[n].last    = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dirty_r  <= 1'b0;
      bpa_r    <= '0;
      bytes_r  <= '1;
      sticky_r <= 1'b0;
      head_r   <= '0;
      tail_r   <= '0;
      cnt_r    <= '0;
    end else begin
      if (take) begin
        dirty_r  <= dirty;
        bpa_r    <= bpa;
        bytes_r  <= bytes;
        sticky_r <= sticky;
        tail_r   <= tail_r + OPTR_W'(npush);
      end
      if (pop) begin
        head_r <= head_r + OPTR_W'(1);
      end
      cnt_r <= cnt_r + (take ? (OPTR_W+1)'(npush) : '0) - (OPTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int k = 0; k < MAX_RES; k++) begin
        if (2'(k) < npush) begin
          fifo_r[tail_r + OPTR_W'(k)] <= recs[k];
        end
      end
    end
  end

  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (OPTR_W+1)'(OUT_DEPTH))
    else $error("result FIFO overfilled");

  a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_command == CMD_STATUS)))
    else $error("last flag not on the status result");

  a_cmd_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_command == CMD_PROGRAM || out_command == CMD_ERASE) |->
      !out_status)
    else $error("command result carries error status");

  a_sticky_write: assert property (@(posedge clk) disable iff (!rst_n)
    take && sticky_r && req.op == OP_WRITE |=> sticky_r && ($past(cnt_r) != cnt_r ||
      $past(pop)))
    else $error("write under sticky error changed error state");

endmodule

`default_nettype wire

@@ sim/tb_flash_phrase_write_combiner.sv @@
// ----------------------------------------------------------------------------
// tb_flash_phrase_write_combiner
// Self-checking bench for the phrase write combiner. A scoreboard class
// tracks the slot registers, the phrase buffer and the sticky error, and
// predicts the program, erase and status results of every accepted request.
// A directed pass covers the corner cases, then randomized traffic runs
// under several slot layouts, with random stalls on both channels but in the last.
// ----------------------------------------------------------------------------

class flash_cmd_scoreboard;
  fpwc_pkg::rec_t pending_cmds[$];
  int unsigned    failures;

  logic [31:0] app_base;
  logic [31:0] backup_base;
  logic [31:0] slot_size;
  logic [4:0]  sector_log2;
  logic        flash_on;

  logic        dirty;
  logic [31:0] open_pa;
  logic [7:0]  gathered [fpwc_pkg::PHRASE_BYTES];
  logic        sticky;

  function new();
    app_base    = '0;
    backup_base = '0;
    slot_size   = '0;
    sector_log2 = fpwc_pkg::SECTOR_LOG2_RST;
    flash_on    = 1'b0;
    sticky      = 1'b0;
    failures    = 0;
    open_phrase('0);
  endfunction

  function void set_reg(logic [fpwc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    case (idx)
      fpwc_pkg::REG_APP_BASE:    app_base = val;
      fpwc_pkg::REG_BACKUP_BASE: backup_base = val;
      fpwc_pkg::REG_SLOT_SIZE:   slot_size = val;
      fpwc_pkg::REG_SECTOR_LOG2: sector_log2 = val[4:0];
      fpwc_pkg::REG_FLASH_ON:    flash_on = val[0];
      default: ;
    endcase
  endfunction

  function void open_phrase(logic [31:0] pa);
    open_pa = pa;
    foreach (gathered[i]) gathered[i] = 8'hFF;
    dirty = 1'b0;
  endfunction

  // Range test modulo 2^32: nonzero length, start at or above base, fits.
  function bit fits(logic [31:0] base, logic [31:0] size, logic [31:0] addr,
                    logic [31:0] len);
    logic [31:0] room;
    room = base + size - addr;
    if (len == 0 || addr < base) return 1'b0;
    return len <= room;
  endfunction

  function void push_result(logic [1:0] cmd, logic [31:0] addr, logic [63:0] data,
                            logic [31:0] len, logic st, logic fin);
    pending_cmds.push_back(fpwc_pkg::rec_t'{cmd, addr, data, len, st, fin});
  endfunction

  // Program a dirty phrase; returns 1 when flash is not ready.
  function bit flush_phrase();
    logic [63:0] word;
    word = '0;
    if (!dirty) return 1'b0;
    dirty = 1'b0;
    if (!flash_on) begin
      sticky = 1'b1;
      return 1'b1;
    end
    foreach (gathered[i]) word[8*i +: 8] = gathered[i];
    push_result(fpwc_pkg::CMD_PROGRAM, open_pa, word, '0, 1'b0, 1'b0);
    return 1'b0;
  endfunction

  function void note_request(logic [1:0] op, logic [31:0] addr, logic [7:0] data,
                             logic [31:0] count);
    logic [31:0] mapped;
    logic [31:0] pa;
    logic [31:0] sec;
    logic [31:0] es;
    logic [31:0] ee;
    logic [fpwc_pkg::OFF_W-1:0] off;
    bit err;
    err = 1'b0;
    case (op)
      fpwc_pkg::OP_WRITE: begin
        if (sticky) begin
          err = 1'b1;
        end else if (!fits(app_base, slot_size, addr, 32'd1)) begin
          sticky = 1'b1;
          err = 1'b1;
        end else begin
          mapped = backup_base + (addr - app_base);
          off = mapped[fpwc_pkg::OFF_W-1:0];
          pa = mapped - 32'(off);
          if (!dirty || open_pa != pa) begin
            if (flush_phrase()) err = 1'b1;
            else open_phrase(pa);
          end
          if (!err) begin
            gathered[off] = data;
            dirty = 1'b1;
            if (off == fpwc_pkg::OFF_LAST && flush_phrase()) err = 1'b1;
          end
        end
      end
      fpwc_pkg::OP_ERASE: begin
        if (flush_phrase()) begin
          err = 1'b1;
        end else if (!fits(app_base, slot_size, addr, count)) begin
          err = 1'b1;
        end else begin
          sec = 32'd1 << sector_log2;
          mapped = backup_base + (addr - app_base);
          es = mapped & ~(sec - 32'd1);
          ee = (mapped + count + sec - 32'd1) & ~(sec - 32'd1);
          if (!fits(backup_base, slot_size, es, ee - es)) begin
            err = 1'b1;
          end else begin
            if (flash_on) begin
              push_result(fpwc_pkg::CMD_ERASE, es, '0, ee - es, 1'b0, 1'b0);
              sticky = 1'b0;
            end else begin
              sticky = 1'b1;
              err = 1'b1;
            end
            open_phrase('0);
          end
        end
      end
      fpwc_pkg::OP_FLUSH: err = flush_phrase();
      default: err = 1'b1;
    endcase
    push_result(fpwc_pkg::CMD_STATUS, '0, '0, '0, err, 1'b1);
  endfunction

  function void compare(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
      failures++;
    end
  endfunction

  function void check_result(fpwc_pkg::rec_t got);
    fpwc_pkg::rec_t want;
    if (pending_cmds.size() == 0) begin
      $display("%0t: unexpected result: expected none, got command %0d address %h",
               $time, got.command, got.flash_address);
      failures++;
      return;
    end
    want = pending_cmds.pop_front();
    compare("command", want.command, got.command);
    compare("flash_address", want.flash_address, got.flash_address);
    compare("phrase_data", want.phrase_data, got.phrase_data);
    compare("erase_length", want.erase_length, got.erase_length);
    compare("status", want.status, got.status);
    compare("last", want.last, got.last);
  endfunction
endclass

module tb_flash_phrase_write_combiner;
  import fpwc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           in_operation;
  logic [31:0]          in_address;
  logic [7:0]           in_data_byte;
  logic [31:0]          in_byte_count;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           out_command;
  logic [31:0]          out_flash_address;
  logic [63:0]          out_phrase_data;
  logic [31:0]          out_erase_length;
  logic                 out_status;
  logic                 out_last;

  flash_cmd_scoreboard flash_cmds;
  bit                  calm;
  int unsigned         stall_left = 0;
  int unsigned         cycles = 0;

  always #1 clk = ~clk;

  flash_phrase_write_combiner dut (.*);

  // Result side: random stall bursts, none once the run turns calm.
  always @(posedge clk) begin
    if (!calm && stall_left == 0 && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 19);
    if (calm || stall_left == 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      stall_left--;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** flash_phrase_write_combiner: FAILED **");
      $finish;
    end
    if (rst_n && out_valid && out_ready)
      flash_cmds.check_result(rec_t'{out_command, out_flash_address, out_phrase_data,
                                     out_erase_length, out_status, out_last});
  end

  task automatic send_request(logic [1:0] op, logic [31:0] addr, logic [7:0] data,
                              logic [31:0] count);
    if (!calm && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_address    <= addr;
    in_data_byte  <= data;
    in_byte_count <= count;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    flash_cmds.note_request(op, addr, data, count);
  endtask

  // Hold the sender until every predicted result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (flash_cmds.pending_cmds.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    flash_cmds.set_reg(idx, val);
  endtask

  task automatic configure(logic [31:0] app, logic [31:0] backup, logic [31:0] size,
                           logic [4:0] log2, logic ready);
    write_reg(REG_APP_BASE, app);
    write_reg(REG_BACKUP_BASE, backup);
    write_reg(REG_SLOT_SIZE, size);
    write_reg(REG_SECTOR_LOG2, 32'(log2));
    write_reg(REG_FLASH_ON, 32'(ready));
    cfg_wr_en <= 1'b0;
  endtask

  task automatic typical_setup(bit unaligned, logic ready);
    logic [4:0]  log2;
    logic [31:0] sec;
    logic [31:0] app;
    logic [31:0] backup;
    log2   = 5'($urandom_range(4, 16));
    sec    = 32'd1 << log2;
    app    = $urandom & ~(sec - 32'd1);
    backup = $urandom & ~(sec - 32'd1);
    if (unaligned) begin
      app    = $urandom;
      backup = $urandom;
    end
    configure(app, backup, sec * $urandom_range(1, 8), log2, ready);
  endtask

  task automatic random_traffic(int unsigned n_items);
    int unsigned sent;
    int unsigned run;
    int unsigned pick;
    bit          paused;
    logic [31:0] addr;
    logic [31:0] span;
    logic [31:0] sec;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      if (!paused && sent >= n_items / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      span = (flash_cmds.slot_size == 0) ? 32'd1 : flash_cmds.slot_size;
      addr = flash_cmds.app_base + $urandom % span;
      sec  = 32'd1 << flash_cmds.sector_log2;
      if (pick < 62) begin
        // sequential bytes; start on a phrase boundary now and then
        run = $urandom_range(1, 12);
        if (pick < 25) addr = addr & ~32'(PHRASE_BYTES - 1);
        repeat (run) begin
          send_request(OP_WRITE, addr, 8'($urandom), $urandom);
          addr++;
        end
        sent += run;
      end else begin
        if (pick < 65)
          send_request(OP_ERASE, flash_cmds.app_base, 8'($urandom), flash_cmds.slot_size);
        else if (pick < 77)
          send_request(OP_ERASE, addr, 8'($urandom), $urandom_range(1, 2 * sec));
        else if (pick < 88)
          send_request(OP_FLUSH, $urandom, 8'($urandom), $urandom);
        else if (pick < 94)
          send_request(OP_WRITE, $urandom, 8'($urandom), $urandom);
        else if (pick < 97)
          send_request(OP_ERASE, $urandom, 8'($urandom), $urandom);
        else
          send_request(OP_UNUSED, $urandom, 8'($urandom), $urandom);
        sent++;
      end
    end
  endtask

  initial begin
    flash_cmds    = new();
    rst_n         <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    in_operation  <= OP_WRITE;
    in_address    <= '0;
    in_data_byte  <= '0;
    in_byte_count <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset layout: empty slot, flash not ready.
    send_request(OP_WRITE, 32'h0000_0000, 8'h00, 32'h0000_0000);
    send_request(OP_FLUSH, 32'h0000_0000, 8'h00, 32'h0000_0000);
    send_request(OP_ERASE, 32'h0000_0000, 8'h00, 32'h0000_0000);
    send_request(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
    wait_drained();

    configure(32'h0001_0000, 32'h0008_0000, 32'h0000_4000, 5'd10, 1'b1);
    send_request(OP_ERASE, 32'h0001_0000, 8'h00, 32'h0000_4000);
    send_request(OP_WRITE, 32'h0001_0000, 8'h00, 32'h0);
    send_request(OP_WRITE, 32'h0001_0001, 8'hFF, 32'h0);
    send_request(OP_WRITE, 32'h0001_0002, 8'hA5, 32'h0);
    send_request(OP_WRITE, 32'h0001_0003, 8'h5A, 32'h0);
    send_request(OP_WRITE, 32'h0001_0004, 8'h01, 32'h0);
    send_request(OP_WRITE, 32'h0001_0005, 8'h80, 32'h0);
    send_request(OP_WRITE, 32'h0001_0006, 8'h7F, 32'h0);
    send_request(OP_WRITE, 32'h0001_0007, 8'hC3, 32'h0);
    send_request(OP_WRITE, 32'h0001_0013, 8'h5A, 32'h0);
    send_request(OP_WRITE, 32'h0001_0020, 8'hFF, 32'h0);
    send_request(OP_FLUSH, 32'h0, 8'h0, 32'h0);
    send_request(OP_WRITE, 32'h0001_0027, 8'h3C, 32'h0);
    send_request(OP_ERASE, 32'h0001_0100, 8'h0, 32'hFFFF_FFFF);
    send_request(OP_WRITE, 32'h0000_FFFF, 8'h11, 32'h0);
    send_request(OP_WRITE, 32'h0001_0030, 8'h22, 32'h0);
    send_request(OP_ERASE, 32'h0001_3FFF, 8'h0, 32'h0000_0001);
    // pending phrase ahead of an erase: program, erase, status
    send_request(OP_WRITE, 32'h0001_0031, 8'h3C, 32'h0);
    send_request(OP_ERASE, 32'h0001_0040, 8'h0, 32'h0000_0040);
    wait_drained();

    configure(32'h0001_0000, 32'h0008_0000, 32'h0000_4000, 5'd10, 1'b0);
    send_request(OP_WRITE, 32'h0001_0008, 8'h77, 32'h0);
    send_request(OP_FLUSH, 32'h0, 8'h0, 32'h0);
    send_request(OP_ERASE, 32'h0001_0000, 8'h0, 32'h0000_0010);

    for (int ph = 0; ph < 7; ph++) begin
      wait_drained();
      case (ph)
        0, 5:    typical_setup(1'b0, 1'b1);
        1:       configure(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 5'd16, 1'b1);
        2:       configure(32'hFFFF_FF00, 32'hFFFF_FF00, 32'h0000_0100, 5'd4, 1'b1);
        3:       typical_setup(1'b1, 1'b1);
        4:       typical_setup(1'b0, 1'b0);
        default: begin
          calm = 1'b1;
          typical_setup(1'b0, 1'b1);
        end
      endcase
      random_traffic(46);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (flash_cmds.failures == 0 && flash_cmds.pending_cmds.size() == 0)
      $display("** flash_phrase_write_combiner: PASSED **");
    else
      $display("** flash_phrase_write_combiner: FAILED **");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/fpwc_pkg.sv
hdl/fpwc_front.sv
hdl/fpwc_queue.sv
hdl/fpwc_back.sv
hdl/flash_phrase_write_combiner.sv
sim/tb_flash_phrase_write_combiner.sv
